@@ rtl/rrg_pkg.sv @@
// Shared types, codes and constants for the reference ramp generator.
package rrg_pkg;

  localparam int STEP_W  = 23;
  localparam int LEVEL_W = 24;
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DIVQ_W  = DATA_W + FRAC_W;
  localparam int QSAT_W  = 19;
  localparam int PROD_W  = 25;
  localparam int RES_W   = 27;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_SET    = 3'd1;
  localparam logic [2:0] ACT_INC    = 3'd2;
  localparam logic [2:0] ACT_DEC    = 3'd3;
  localparam logic [2:0] ACT_ADJUST = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_LIMIT = 2'd2;

  localparam logic [2:0] REG_RISE      = 3'd0;
  localparam logic [2:0] REG_FALL      = 3'd1;
  localparam logic [2:0] REG_FAST_FALL = 3'd2;
  localparam logic [2:0] REG_NUDGE     = 3'd3;
  localparam logic [2:0] REG_FAST_MODE = 3'd4;
  localparam logic [2:0] REG_MIN       = 3'd5;
  localparam logic [2:0] REG_MAX       = 3'd6;

  localparam logic [STEP_W-1:0] REF_MAX_RST = 23'd6553600;
  localparam logic [6:0]        PERCENT     = 7'd100;

  typedef struct packed {
    logic [STEP_W-1:0]  rise_step;
    logic [STEP_W-1:0]  fall_step;
    logic [STEP_W-1:0]  fast_fall_step;
    logic [STEP_W-1:0]  nudge_step;
    logic               fast_stop;
    logic [LEVEL_W-1:0] ref_min;
    logic [STEP_W-1:0]  ref_max;
  } rrg_cfg_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic commit;
  } rrg_cmd_t;

  typedef struct packed {
    logic is_adjust;
    logic div_done;
  } rrg_sts_t;

endpackage

@@ rtl/rrg_regs.sv @@
// Configuration register file behind the APB-style port.
module rrg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rrg_pkg::rrg_cfg_t cfg
);

  rrg_pkg::rrg_cfg_t cfg_r;
  logic              wr_en;
  logic [2:0]        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rise_step:      '0,
                 fall_step:      '0,
                 fast_fall_step: '0,
                 nudge_step:     '0,
                 fast_stop:      1'b0,
                 ref_min:        '0,
                 ref_max:        rrg_pkg::REF_MAX_RST};
    end else if (wr_en) begin
      unique case (idx)
        rrg_pkg::REG_RISE:      cfg_r.rise_step      <= pwdata[rrg_pkg::STEP_W-1:0];
        rrg_pkg::REG_FALL:      cfg_r.fall_step      <= pwdata[rrg_pkg::STEP_W-1:0];
        rrg_pkg::REG_FAST_FALL: cfg_r.fast_fall_step <= pwdata[rrg_pkg::STEP_W-1:0];
        rrg_pkg::REG_NUDGE:     cfg_r.nudge_step     <= pwdata[rrg_pkg::STEP_W-1:0];
        rrg_pkg::REG_FAST_MODE: cfg_r.fast_stop      <= pwdata[0];
        rrg_pkg::REG_MIN:       cfg_r.ref_min        <= pwdata[rrg_pkg::LEVEL_W-1:0];
        rrg_pkg::REG_MAX:       cfg_r.ref_max        <= pwdata[rrg_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rrg_pkg::REG_RISE:      prdata = {9'd0, cfg_r.rise_step};
      rrg_pkg::REG_FALL:      prdata = {9'd0, cfg_r.fall_step};
      rrg_pkg::REG_FAST_FALL: prdata = {9'd0, cfg_r.fast_fall_step};
      rrg_pkg::REG_NUDGE:     prdata = {9'd0, cfg_r.nudge_step};
      rrg_pkg::REG_FAST_MODE: prdata = {31'd0, cfg_r.fast_stop};
      rrg_pkg::REG_MIN:       prdata = {{8{cfg_r.ref_min[23]}}, cfg_r.ref_min};
      rrg_pkg::REG_MAX:       prdata = {9'd0, cfg_r.ref_max};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/rrg_div.sv @@
// Radix-2 restoring divider: 48-bit dividend magnitude by 32-bit divisor, one bit a cycle.
module rrg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rrg_pkg::DATA_W-1:0] num_mag,
  input  logic [rrg_pkg::DATA_W-1:0] den_mag,
  output logic [rrg_pkg::DIVQ_W-1:0] quo,
  output logic                       done
);

  logic [rrg_pkg::DIVQ_W-1:0] dq_r, dq_nxt;
  logic [rrg_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [rrg_pkg::DATA_W-1:0] den_r;
  logic [5:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [rrg_pkg::DATA_W:0]   trial;
  logic [rrg_pkg::DATA_W:0]   diff;
  logic                       ge;

  assign trial = {rem_r, dq_r[rrg_pkg::DIVQ_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign quo   = dq_r;
  assign done  = done_r;

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = {num_mag, {rrg_pkg::FRAC_W{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[rrg_pkg::DIVQ_W-2:0], ge};
      rem_nxt = ge ? diff[rrg_pkg::DATA_W-1:0] : trial[rrg_pkg::DATA_W-1:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(rrg_pkg::DIVQ_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den_mag;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not go busy after start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r))) else $error("divider done without a run");

endmodule

@@ rtl/rrg_datapath.sv @@
// Reference state, per-action arithmetic, divider and output register.
module rrg_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rrg_pkg::rrg_cfg_t cfg,
  input  rrg_pkg::rrg_cmd_t cmd,
  output rrg_pkg::rrg_sts_t sts,
  input  logic [63:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  output logic [47:0]       out_tdata,
  output logic [2:0]        out_tuser
);

  localparam int LW = rrg_pkg::LEVEL_W;
  localparam int DW = rrg_pkg::DATA_W;
  localparam int SW = rrg_pkg::STEP_W;
  localparam int RW = rrg_pkg::RES_W;

  logic [2:0]            act_r;
  logic signed [DW-1:0]  val_r;
  logic signed [DW-1:0]  max_r;
  logic signed [LW-1:0]  cur_r, cur_nxt;
  logic signed [LW-1:0]  tgt_r, tgt_nxt;
  logic                  reached;
  logic [1:0]            status;

  logic signed [LW-1:0]  out_cur_r, out_tgt_r;
  logic                  out_reached_r;
  logic [1:0]            out_status_r;

  // Operands brought to common widths.
  logic signed [DW-1:0]  min32, max32;
  logic signed [LW+1:0]  min26, max26, tgt26, t_inc, t_dec;
  logic signed [LW:0]    dr;
  logic [LW:0]           mag;
  logic [SW-1:0]         step;
  logic signed [LW:0]    step25;
  logic signed [LW:0]    moved;

  logic [DW-1:0]                 v_mag, m_mag;
  logic [rrg_pkg::DIVQ_W-1:0]    quo;
  logic                          div_done;
  logic [rrg_pkg::QSAT_W-1:0]    qsat;
  logic [rrg_pkg::PROD_W-1:0]    prod;
  logic signed [RW-1:0]          r_val, min27, max27;

  assign min32  = {{(DW-LW){cfg.ref_min[LW-1]}}, cfg.ref_min};
  assign max32  = {{(DW-SW){1'b0}}, cfg.ref_max};
  assign min26  = {{2{cfg.ref_min[LW-1]}}, cfg.ref_min};
  assign max26  = {3'b000, cfg.ref_max};
  assign tgt26  = {{2{tgt_r[LW-1]}}, tgt_r};
  assign t_inc  = tgt26 + {3'b000, cfg.nudge_step};
  assign t_dec  = tgt26 - {3'b000, cfg.nudge_step};
  assign dr     = {cur_r[LW-1], cur_r} - {tgt_r[LW-1], tgt_r};
  assign mag    = dr[LW] ? 25'(-dr) : 25'(dr);
  assign step   = dr[LW] ? cfg.rise_step :
                  (cfg.fast_stop ? cfg.fast_fall_step : cfg.fall_step);
  assign step25 = {2'b00, step};
  assign moved  = dr[LW] ? ({cur_r[LW-1], cur_r} + step25)
                         : ({cur_r[LW-1], cur_r} - step25);

  assign v_mag = val_r[DW-1] ? DW'(-val_r) : DW'(val_r);
  assign m_mag = max_r[DW-1] ? DW'(-max_r) : DW'(max_r);

  rrg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num_mag (v_mag),
    .den_mag (m_mag),
    .quo     (quo),
    .done    (div_done)
  );

  // Anything at or above 2^18 already lies far outside the reference range after scaling.
  assign qsat  = (|quo[rrg_pkg::DIVQ_W-1:rrg_pkg::QSAT_W-1]) ?
                 {1'b1, {(rrg_pkg::QSAT_W-1){1'b0}}} :
                 {1'b0, quo[rrg_pkg::QSAT_W-2:0]};
  assign prod  = rrg_pkg::PROD_W'(qsat * rrg_pkg::PERCENT);
  assign r_val = (val_r[DW-1] ^ max_r[DW-1]) ? -$signed({2'b00, prod})
                                              : $signed({2'b00, prod});
  assign min27 = {{(RW-LW){cfg.ref_min[LW-1]}}, cfg.ref_min};
  assign max27 = {{(RW-SW){1'b0}}, cfg.ref_max};

  assign sts.is_adjust = (act_r == rrg_pkg::ACT_ADJUST);
  assign sts.div_done  = div_done;

  always_comb begin
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    reached = 1'b0;
    status  = rrg_pkg::STAT_OK;
    unique case (act_r)
      rrg_pkg::ACT_TICK: begin
        if (cur_r == tgt_r) begin
          reached = 1'b1;
        end else if (mag < step25) begin
          cur_nxt = tgt_r;
          reached = 1'b1;
        end else begin
          cur_nxt = moved[LW-1:0];
        end
      end
      rrg_pkg::ACT_SET: begin
        if (val_r > max32 || val_r < min32) begin
          status = rrg_pkg::STAT_RANGE;
        end else begin
          tgt_nxt = val_r[LW-1:0];
        end
      end
      rrg_pkg::ACT_INC: begin
        if (tgt26 == max26) begin
          status = rrg_pkg::STAT_LIMIT;
        end else if (t_inc > max26) begin
          tgt_nxt = max26[LW-1:0];
        end else begin
          tgt_nxt = t_inc[LW-1:0];
        end
      end
      rrg_pkg::ACT_DEC: begin
        if (tgt26 == min26) begin
          status = rrg_pkg::STAT_LIMIT;
        end else if (t_dec < min26) begin
          tgt_nxt = min26[LW-1:0];
        end else begin
          tgt_nxt = t_dec[LW-1:0];
        end
      end
      rrg_pkg::ACT_ADJUST: begin
        priority if (val_r <= min32) begin
          cur_nxt = '0;
        end else if (val_r >= max_r) begin
          cur_nxt = {1'b0, cfg.ref_max};
        end else if (max_r == '0) begin
          cur_nxt = cfg.ref_min;
        end else if (r_val < min27) begin
          cur_nxt = cfg.ref_min;
        end else if (r_val > max27) begin
          cur_nxt = {1'b0, cfg.ref_max};
        end else begin
          cur_nxt = r_val[LW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_tuser;
      val_r <= in_tdata[31:0];
      max_r <= in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r         <= '0;
      tgt_r         <= '0;
      out_cur_r     <= '0;
      out_tgt_r     <= '0;
      out_reached_r <= 1'b0;
      out_status_r  <= rrg_pkg::STAT_OK;
    end else if (cmd.commit) begin
      cur_r         <= cur_nxt;
      tgt_r         <= tgt_nxt;
      out_cur_r     <= cur_nxt;
      out_tgt_r     <= tgt_nxt;
      out_reached_r <= reached;
      out_status_r  <= status;
    end
  end

  assign out_tdata = {out_tgt_r, out_cur_r};
  assign out_tuser = {out_status_r, out_reached_r};

  a_reached_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_reached_r |-> (out_cur_r == out_tgt_r))
    else $error("reached flagged while current differs from target");

endmodule

@@ rtl/rrg_ctrl.sv @@
// Sequencing state machine: request intake, divider start, commit and output valid.
module rrg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rrg_pkg::rrg_sts_t sts,
  output rrg_pkg::rrg_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_adjust) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // The result may only land once the output register is free or is being drained.
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r) else $error("commit did not raise output valid");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second request taken too early");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV)) else $error("divider finished outside divide wait");

endmodule

@@ rtl/reference_ramp_generator.sv @@
// Top level of the Q16.16 setpoint ramp generator with slew-rate limiting.
// One request at a time: tick, set, increment and decrement pass from acceptance through the
// exec and commit states; adjust also starts the divider and waits in the divide state until
// the 48-step serial divider is done. Commit waits until the output register is free or drained.
// A new request is taken while the previous result waits in the output register.
// Synchronous active-low reset clears both references, the registers (max to 100.0) and valid.
module reference_ramp_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] value, [63:32] max_value
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [23:0] current_level, [47:24] target_level
  output logic [2:0]  out_tuser,  // [0] reached, [2:1] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  rrg_pkg::rrg_cfg_t cfg;
  rrg_pkg::rrg_cmd_t cmd;
  rrg_pkg::rrg_sts_t sts;

  rrg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rrg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
